// ----- rtl/i2cram_pkg.sv -----
// i2cram_pkg: beat types, segment codes and sequence tables for the i2c
// register access master. No dependencies; imported by the step logic and the top level.
package i2cram_pkg;

   // request beat: one tick of the pin sequencer
   typedef struct packed {
      logic       go;
      logic       func;
      logic [7:0] device_address;
      logic [7:0] register_address;
      logic [7:0] write_data;
      logic       sda_in;
   } req_type;

   // response beat: pin and status view after the tick
   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       sda_drive;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_data;
      logic       nack_seen;
   } rsp_type;

   // sequencer state carried between ticks
   typedef struct packed {
      logic [5:0] step_index;
      logic [2:0] byte_number;
      logic [7:0] shift_register;
      logic       latched_func;
      logic [7:0] latched_device;
      logic [7:0] latched_register;
      logic [7:0] latched_data;
      logic [7:0] received_byte;
      logic       nack_flag;
      logic       scl;
      logic       sda;
      logic       drv;
   } state_type;

   // segment kinds
   localparam logic [2:0] KIND_START = 3'd0;
   localparam logic [2:0] KIND_WBYTE = 3'd1;
   localparam logic [2:0] KIND_RBYTE = 3'd2;
   localparam logic [2:0] KIND_NACK  = 3'd3;
   localparam logic [2:0] KIND_STOP  = 3'd4;

   // segment lengths in ticks
   localparam logic [5:0] LEN_WBYTE = 6'd32;
   localparam logic [5:0] LEN_RBYTE = 6'd22;
   localparam logic [5:0] LEN_SHORT = 6'd5;

   // last segment index of each transaction type
   localparam logic [2:0] LAST_WRITE = 3'd4;
   localparam logic [2:0] LAST_READ  = 3'd7;

   // idle sequencer with SCL and SDA high, SDA released
   function automatic state_type reset_state();
      state_type s;
      s     = '0;
      s.scl = 1'b1;
      s.sda = 1'b1;
      s.drv = 1'b0;
      return s;
   endfunction

   // segment program of a register write
   function automatic logic [2:0] write_kind(input logic [2:0] seg);
      logic [2:0] kind;
      case (seg)
         3'd0:                kind = KIND_START;
         3'd1, 3'd2, 3'd3:    kind = KIND_WBYTE;
         default:             kind = KIND_STOP;
      endcase
      return kind;
   endfunction

   // segment program of a register read
   function automatic logic [2:0] read_kind(input logic [2:0] seg);
      logic [2:0] kind;
      case (seg)
         3'd0, 3'd3:          kind = KIND_START;
         3'd1, 3'd2, 3'd4:    kind = KIND_WBYTE;
         3'd5:                kind = KIND_RBYTE;
         3'd6:                kind = KIND_NACK;
         default:             kind = KIND_STOP;
      endcase
      return kind;
   endfunction

   // tick count of a segment kind
   function automatic logic [5:0] kind_len(input logic [2:0] kind);
      logic [5:0] len;
      case (kind)
         KIND_WBYTE: len = LEN_WBYTE;
         KIND_RBYTE: len = LEN_RBYTE;
         default:    len = LEN_SHORT;
      endcase
      return len;
   endfunction

endpackage

// ----- rtl/i2cram_step.sv -----
// i2cram_step: next-state and response logic for one tick of the i2c
// register access master. Depends on i2cram_pkg.
module i2cram_step (
   input  i2cram_pkg::state_type cur_state,
   input  i2cram_pkg::req_type   req,
   output i2cram_pkg::state_type nxt_state,
   output i2cram_pkg::rsp_type   rsp
);
   import i2cram_pkg::*;

   logic [2:0] seg;
   logic [2:0] kind;
   logic [2:0] last_seg;
   logic [5:0] len;
   logic [5:0] p;
   logic [7:0] seg_byte;
   logic       done;

   // segment decode
   always_comb begin
      seg      = cur_state.byte_number;
      kind     = cur_state.latched_func ? read_kind(seg) : write_kind(seg);
      last_seg = cur_state.latched_func ? LAST_READ : LAST_WRITE;
      len      = kind_len(kind);
      p        = (cur_state.step_index > len) ? len : cur_state.step_index;
      case (seg)
         3'd1:    seg_byte = cur_state.latched_device;
         3'd2:    seg_byte = cur_state.latched_register;
         3'd4:    seg_byte = cur_state.latched_device + 8'd1;
         default: seg_byte = cur_state.latched_data;
      endcase
   end

   // one pin assignment per tick
   always_comb begin
      nxt_state = cur_state;
      done      = 1'b0;
      if (cur_state.step_index == 6'd0) begin
         // idle: latch a request
         if (req.go) begin
            nxt_state.latched_func     = req.func;
            nxt_state.latched_device   = req.device_address;
            nxt_state.latched_register = req.register_address;
            nxt_state.latched_data     = req.write_data;
            nxt_state.nack_flag        = 1'b0;
            nxt_state.byte_number      = 3'd0;
            nxt_state.step_index       = 6'd1;
         end
      end else begin
         case (kind)
            KIND_WBYTE: begin
               case (p) inside
                  6'd1: begin
                     nxt_state.drv            = 1'b1;
                     nxt_state.shift_register = seg_byte;
                  end
                  6'd2, 6'd5, 6'd8, 6'd11, 6'd14, 6'd17, 6'd20, 6'd23:
                     nxt_state.scl = 1'b0;
                  6'd3, 6'd6, 6'd9, 6'd12, 6'd15, 6'd18, 6'd21, 6'd24: begin
                     nxt_state.sda            = cur_state.shift_register[7];
                     nxt_state.shift_register = {cur_state.shift_register[6:0], 1'b0};
                  end
                  6'd4, 6'd7, 6'd10, 6'd13, 6'd16, 6'd19, 6'd22, 6'd25:
                     nxt_state.scl = 1'b1;
                  6'd26, 6'd27, 6'd32:
                     nxt_state.scl = 1'b0;
                  6'd28: nxt_state.drv = 1'b1;
                  6'd29: nxt_state.sda = 1'b1;
                  6'd30: nxt_state.drv = 1'b0;
                  default: begin
                     // ack clock high: sample the slave
                     nxt_state.scl = 1'b1;
                     if (req.sda_in) begin
                        nxt_state.nack_flag = 1'b1;
                     end
                  end
               endcase
            end
            KIND_RBYTE: begin
               case (p) inside
                  6'd1: begin
                     nxt_state.scl            = 1'b0;
                     nxt_state.shift_register = 8'd0;
                  end
                  6'd2, 6'd22: nxt_state.drv = 1'b1;
                  6'd3:        nxt_state.sda = 1'b1;
                  6'd4:        nxt_state.drv = 1'b0;
                  6'd5, 6'd7, 6'd9, 6'd11, 6'd13, 6'd15, 6'd17, 6'd19:
                     nxt_state.scl = 1'b0;
                  6'd6, 6'd8, 6'd10, 6'd12, 6'd14, 6'd16, 6'd18, 6'd20: begin
                     nxt_state.scl            = 1'b1;
                     nxt_state.shift_register = {cur_state.shift_register[6:0], req.sda_in};
                  end
                  default: begin
                     nxt_state.scl           = 1'b0;
                     nxt_state.received_byte = cur_state.shift_register;
                  end
               endcase
            end
            KIND_START: begin
               case (p)
                  6'd1:    nxt_state.drv = 1'b1;
                  6'd2:    nxt_state.sda = 1'b1;
                  6'd3:    nxt_state.scl = 1'b1;
                  6'd4:    nxt_state.sda = 1'b0;
                  default: nxt_state.scl = 1'b0;
               endcase
            end
            KIND_NACK: begin
               case (p)
                  6'd2:    nxt_state.drv = 1'b1;
                  6'd3:    nxt_state.sda = 1'b1;
                  6'd4:    nxt_state.scl = 1'b1;
                  default: nxt_state.scl = 1'b0;
               endcase
            end
            default: begin
               // stop condition
               case (p)
                  6'd1:    nxt_state.scl = 1'b0;
                  6'd2:    nxt_state.drv = 1'b1;
                  6'd3:    nxt_state.sda = 1'b0;
                  6'd4:    nxt_state.scl = 1'b1;
                  default: nxt_state.sda = 1'b1;
               endcase
            end
         endcase

         // advance within the segment, to the next one, or back to idle after the last
         if (p >= len) begin
            if ((kind == KIND_STOP) || (seg >= last_seg)) begin
               nxt_state.step_index  = 6'd0;
               nxt_state.byte_number = 3'd0;
               done                  = 1'b1;
            end else begin
               nxt_state.byte_number = seg + 3'd1;
               nxt_state.step_index  = 6'd1;
            end
         end else begin
            nxt_state.step_index = p + 6'd1;
         end
      end
   end

   // response view of the new state
   always_comb begin
      rsp.scl_level = nxt_state.scl;
      rsp.sda_level = nxt_state.sda;
      rsp.sda_drive = nxt_state.drv;
      rsp.busy_res  = (nxt_state.step_index != 6'd0);
      rsp.done_res  = done;
      rsp.read_data = nxt_state.received_byte;
      rsp.nack_seen = nxt_state.nack_flag;
   end

endmodule

// ----- rtl/i2c_register_access_master_unit.sv -----
// i2c_register_access_master_unit: top level of the pin-level i2c register
// access master. Depends on i2cram_pkg and i2cram_step.
//
//   channel | direction | handshake              | payload
//   req     | in        | req_valid / req_stall  | req_data (req_type)
//   rsp     | out       | rsp_valid / rsp_stall  | rsp_data (rsp_type)
//
// Every req beat is one tick and yields one rsp beat; while req_stall is low, a beat
// can be taken every cycle. The sequencer state loads at the edge that takes the beat;
// so does the response, into the output register or, if that stays full, the skid.
// A two-entry output stage (register plus skid) lets a beat enter while a
// response waits; req_stall rises only when both entries are full.
// Reset (synchronous) returns the sequencer to idle with SCL and SDA high, SDA released.
module i2c_register_access_master_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  i2cram_pkg::req_type  req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output i2cram_pkg::rsp_type  rsp_data
);
   import i2cram_pkg::*;

   state_type state_ff;
   state_type state_in;
   rsp_type   step_rsp;
   rsp_type   out_ff;
   rsp_type   out_in;
   rsp_type   skid_ff;
   rsp_type   skid_in;
   logic      out_valid_ff;
   logic      out_valid_in;
   logic      skid_valid_ff;
   logic      skid_valid_in;
   logic      accept;
   logic      take;

   i2cram_step u_step (
      .cur_state (state_ff),
      .req       (req_data),
      .nxt_state (state_in),
      .rsp       (step_rsp)
   );

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;
   assign take      = out_valid_ff && !rsp_stall;

   // output register and skid entry
   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (take || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_in       = step_rsp;
            skid_valid_in = accept;
         end else begin
            out_in       = step_rsp;
            out_valid_in = accept;
         end
      end else if (accept) begin
         skid_in       = step_rsp;
         skid_valid_in = 1'b1;
      end
   end

   // sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= reset_state();
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   // output stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // output stage payload
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

endmodule
